// ----- src/tcsi_pkg.sv -----
`default_nettype none
package tcsi_pkg;

   // store depths and the address widths that follow from them
   localparam int NEIGHBOR_DEPTH = 524288;
   localparam int OFFSET_DEPTH   = 131072;
   localparam int NBR_ADDR_W     = $clog2(NEIGHBOR_DEPTH);
   localparam int OFS_ADDR_W     = $clog2(OFFSET_DEPTH);
   localparam int PTR_W          = $clog2(NEIGHBOR_DEPTH + 1);

   // item field widths
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 19;
   localparam int WORD_W   = 32;
   localparam int NODE_W   = 17;
   localparam int COUNT_W  = 20;
   localparam int TOTAL_W  = 32;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 56;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // action codes, also used as the kind of a queued item
   localparam logic [ACTION_W-1:0] ACT_NBR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_OFS  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [ACTION_W-1:0] kind;
      logic [INDEX_W-1:0]  index;
      logic [WORD_W-1:0]   data_word;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic                last_edge;
      logic                a_bad;
      logic                b_bad;
   } entry_type;

endpackage
`default_nettype wire

// ----- src/triangle_count_sorted_intersect.sv -----
// a load item is written to its store as it leaves the queue
// an edge goes from queue to result register through S_OFS, S_RANGE, S_MERGE and
//   S_DONE, with n merge steps, n at most len_a + len_b; one merge step a cycle, set by the
//   two-port registered read of the neighbor memory
// one edge at a time in the back end; the 4-deep queue keeps taking items while not full
// reset: synchronous, clears queue, total and result valid; stores undefined until written
`default_nettype none
module triangle_count_sorted_intersect (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input item channel
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // index[18:0], data_word[50:19], first_node[67:51], second_node[84:68], zero fill
   input  wire logic [tcsi_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // action[1:0]
   input  wire logic [tcsi_pkg::ACTION_W-1:0]        req_tuser,
   // last_edge
   input  wire logic                                 req_tlast,
   // result item channel
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // common_count[19:0], running_total[51:20], zero fill
   output logic [tcsi_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   // is_last
   output logic                                      rsp_tlast
);

   localparam int DATA_LO   = tcsi_pkg::INDEX_W;
   localparam int FIRST_LO  = DATA_LO + tcsi_pkg::WORD_W;
   localparam int SECOND_LO = FIRST_LO + tcsi_pkg::NODE_W;
   localparam int RSP_USED  = tcsi_pkg::COUNT_W + tcsi_pkg::TOTAL_W;

   logic                               q_valid;
   logic                               q_ready;
   tcsi_pkg::entry_type                q_entry;
   logic [tcsi_pkg::COUNT_W-1:0]       out_count;
   logic [tcsi_pkg::TOTAL_W-1:0]       out_total;

   // front end: classify items and queue the ones that do work
   tcsi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .action      (req_tuser),
      .index       (req_tdata[DATA_LO-1:0]),
      .data_word   (req_tdata[FIRST_LO-1:DATA_LO]),
      .first_node  (req_tdata[SECOND_LO-1:FIRST_LO]),
      .second_node (req_tdata[SECOND_LO+tcsi_pkg::NODE_W-1:SECOND_LO]),
      .last_edge   (req_tlast),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_entry     (q_entry)
   );

   // back end: store writes, offset lookup, merge walk, result register
   tcsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_entry   (q_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_count (out_count),
      .out_total (out_total),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(tcsi_pkg::RSP_TDATA_W - RSP_USED){1'b0}}, out_total, out_count};

endmodule
`default_nettype wire

// ----- src/tcsi_front.sv -----
`default_nettype none
module tcsi_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic [tcsi_pkg::ACTION_W-1:0]     action,
   input  wire logic [tcsi_pkg::INDEX_W-1:0]      index,
   input  wire logic [tcsi_pkg::WORD_W-1:0]       data_word,
   input  wire logic [tcsi_pkg::NODE_W-1:0]       first_node,
   input  wire logic [tcsi_pkg::NODE_W-1:0]       second_node,
   input  wire logic                              last_edge,
   output logic                                   q_valid,
   input  wire logic                              q_ready,
   output tcsi_pkg::entry_type                    q_entry
);

   tcsi_pkg::entry_type               queue_mem [tcsi_pkg::QUEUE_DEPTH];
   logic [tcsi_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcsi_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcsi_pkg::QCNT_W-1:0]       count_ff, count_in;
   tcsi_pkg::entry_type               entry;
   logic                              keep;
   logic                              push;
   logic                              pop;

   // classify: drop unused actions and loads beyond their store
   always_comb begin
      keep = 1'b0;
      priority if (action == tcsi_pkg::ACT_NBR) begin
         keep = 32'(index) < 32'(tcsi_pkg::NEIGHBOR_DEPTH);
      end else if (action == tcsi_pkg::ACT_OFS) begin
         keep = 32'(index) < 32'(tcsi_pkg::OFFSET_DEPTH);
      end else if (action == tcsi_pkg::ACT_EDGE) begin
         keep = 1'b1;
      end else begin
         keep = 1'b0;
      end
   end

   always_comb begin
      entry.kind      = action;
      entry.index     = index;
      entry.data_word = data_word;
      entry.node_a    = first_node;
      entry.node_b    = second_node;
      entry.last_edge = last_edge;
      // node whose successor lies past the offset store has an empty range
      entry.a_bad     = (32'(first_node) + 32'd1) >= 32'(tcsi_pkg::OFFSET_DEPTH);
      entry.b_bad     = (32'(second_node) + 32'd1) >= 32'(tcsi_pkg::OFFSET_DEPTH);
   end

   assign in_ready = count_ff != tcsi_pkg::QCNT_W'(tcsi_pkg::QUEUE_DEPTH);
   assign push     = in_valid && in_ready && keep;
   assign q_valid  = count_ff != '0;
   assign pop      = q_valid && q_ready;
   assign q_entry  = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tcsi_pkg::QCNT_W'(tcsi_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue push lost");

endmodule
`default_nettype wire

// ----- src/tcsi_back.sv -----
`default_nettype none
module tcsi_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   output logic                                q_ready,
   input  wire tcsi_pkg::entry_type            q_entry,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [tcsi_pkg::COUNT_W-1:0]        out_count,
   output logic [tcsi_pkg::TOTAL_W-1:0]        out_total,
   output logic                                out_last
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_OFS   = 3'd1;
   localparam logic [2:0] S_RANGE = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [2:0] STEP_LAST = 3'd4;

   logic [tcsi_pkg::WORD_W-1:0]     nbr_mem [tcsi_pkg::NEIGHBOR_DEPTH];
   logic [tcsi_pkg::WORD_W-1:0]     ofs_mem [tcsi_pkg::OFFSET_DEPTH];

   logic [2:0]                      state_ff, state_in;
   logic [2:0]                      step_ff, step_in;
   tcsi_pkg::entry_type             edge_ff, edge_in;
   logic [tcsi_pkg::WORD_W-1:0]     a_s_ff, a_s_in, a_e_ff, a_e_in;
   logic [tcsi_pkg::WORD_W-1:0]     b_s_ff, b_s_in, b_e_ff, b_e_in;
   logic [tcsi_pkg::PTR_W-1:0]      a_ptr_ff, a_ptr_in, a_end_ff, a_end_in;
   logic [tcsi_pkg::PTR_W-1:0]      b_ptr_ff, b_ptr_in, b_end_ff, b_end_in;
   logic [tcsi_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [tcsi_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic [tcsi_pkg::WORD_W-1:0]     nbr_a_ff, nbr_b_ff, ofs_q_ff;
   logic [tcsi_pkg::OFS_ADDR_W-1:0] ofs_addr;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tcsi_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [tcsi_pkg::TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            pop;
   logic                            out_free;
   logic                            done_fire;
   logic [tcsi_pkg::TOTAL_W-1:0]    sum;
   logic                            a_empty, b_empty;
   logic [tcsi_pkg::WORD_W-1:0]     a_clip, b_clip;

   assign q_ready   = state_ff == S_IDLE;
   assign pop       = q_valid && q_ready;
   assign out_free  = !rsp_valid_ff || out_ready;
   assign done_fire = (state_ff == S_DONE) && out_free;
   assign sum       = total_ff + tcsi_pkg::TOTAL_W'(count_ff);

   // offset reads: start and end of the first node, then of the second
   always_comb begin
      unique case (step_ff)
         3'd0:    ofs_addr = tcsi_pkg::OFS_ADDR_W'(edge_ff.node_a);
         3'd1:    ofs_addr = tcsi_pkg::OFS_ADDR_W'(edge_ff.node_a) + 1'b1;
         3'd2:    ofs_addr = tcsi_pkg::OFS_ADDR_W'(edge_ff.node_b);
         default: ofs_addr = tcsi_pkg::OFS_ADDR_W'(edge_ff.node_b) + 1'b1;
      endcase
   end

   // clip end offsets to the store, empty on reversed range or bad node
   always_comb begin
      a_clip  = (a_e_ff > 32'(tcsi_pkg::NEIGHBOR_DEPTH)) ?
                32'(tcsi_pkg::NEIGHBOR_DEPTH) : a_e_ff;
      b_clip  = (b_e_ff > 32'(tcsi_pkg::NEIGHBOR_DEPTH)) ?
                32'(tcsi_pkg::NEIGHBOR_DEPTH) : b_e_ff;
      a_empty = edge_ff.a_bad || (a_s_ff >= a_clip);
      b_empty = edge_ff.b_bad || (b_s_ff >= b_clip);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      edge_in      = edge_ff;
      a_s_in       = a_s_ff;
      a_e_in       = a_e_ff;
      b_s_in       = b_s_ff;
      b_e_in       = b_e_ff;
      a_ptr_in     = a_ptr_ff;
      b_ptr_in     = b_ptr_ff;
      a_end_in     = a_end_ff;
      b_end_in     = b_end_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (pop && (q_entry.kind == tcsi_pkg::ACT_EDGE)) begin
               edge_in  = q_entry;
               step_in  = '0;
               state_in = S_OFS;
            end
         end
         S_OFS: begin
            unique case (step_ff)
               3'd1:    a_s_in = ofs_q_ff;
               3'd2:    a_e_in = ofs_q_ff;
               3'd3:    b_s_in = ofs_q_ff;
               3'd4:    b_e_in = ofs_q_ff;
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            a_ptr_in = a_empty ? '0 : tcsi_pkg::PTR_W'(a_s_ff);
            a_end_in = a_empty ? '0 : tcsi_pkg::PTR_W'(a_clip);
            b_ptr_in = b_empty ? '0 : tcsi_pkg::PTR_W'(b_s_ff);
            b_end_in = b_empty ? '0 : tcsi_pkg::PTR_W'(b_clip);
            count_in = '0;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            if ((a_ptr_ff < a_end_ff) && (b_ptr_ff < b_end_ff)) begin
               priority if (nbr_a_ff < nbr_b_ff) begin
                  a_ptr_in = a_ptr_ff + 1'b1;
               end else if (nbr_a_ff > nbr_b_ff) begin
                  b_ptr_in = b_ptr_ff + 1'b1;
               end else begin
                  a_ptr_in = a_ptr_ff + 1'b1;
                  b_ptr_in = b_ptr_ff + 1'b1;
                  if (count_ff != tcsi_pkg::COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_total_in = sum;
               rsp_last_in  = edge_ff.last_edge;
               total_in     = edge_ff.last_edge ? '0 : sum;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // neighbor store: one write port, two read ports following the pointers
   always_ff @(posedge clock) begin
      if (pop && (q_entry.kind == tcsi_pkg::ACT_NBR)) begin
         nbr_mem[tcsi_pkg::NBR_ADDR_W'(q_entry.index)] <= q_entry.data_word;
      end
      nbr_a_ff <= nbr_mem[tcsi_pkg::NBR_ADDR_W'(a_ptr_in)];
      nbr_b_ff <= nbr_mem[tcsi_pkg::NBR_ADDR_W'(b_ptr_in)];
   end

   always_ff @(posedge clock) begin
      if (pop && (q_entry.kind == tcsi_pkg::ACT_OFS)) begin
         ofs_mem[tcsi_pkg::OFS_ADDR_W'(q_entry.index)] <= q_entry.data_word;
      end
      ofs_q_ff <= ofs_mem[ofs_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      edge_ff      <= edge_in;
      a_s_ff       <= a_s_in;
      a_e_ff       <= a_e_in;
      b_s_ff       <= b_s_in;
      b_e_ff       <= b_e_in;
      a_ptr_ff     <= a_ptr_in;
      b_ptr_ff     <= b_ptr_in;
      a_end_ff     <= a_end_in;
      b_end_ff     <= b_end_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_count = rsp_count_ff;
   assign out_total = rsp_total_ff;
   assign out_last  = rsp_last_ff;

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> ((a_ptr_ff <= a_end_ff) && (b_ptr_ff <= b_end_ff)))
      else $error("merge pointer ran past its range end");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MERGE) && ($past(state_ff) == S_MERGE)) |->
      (count_ff >= $past(count_ff)))
      else $error("common count went down during a merge");

   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      (done_fire && edge_ff.last_edge) |=> (total_ff == '0))
      else $error("total not cleared after last edge");

endmodule
`default_nettype wire
